@@ hw/rtl/rpe_pkg.sv @@
// Package of the rational polynomial evaluator: register indexes, fixed widths,
// clamp limits and the control words that travel down the cell chains.
// Depends on nothing; every other file of the block uses it.
package rpe_pkg;

  localparam int COEF_W = 32;
  localparam int ACC_W  = 64;
  localparam int NREGS  = 8;
  localparam int IDX_W  = 8;

  localparam logic [IDX_W-1:0] REG_NUM0 = 8'd0;
  localparam logic [IDX_W-1:0] REG_DEN0 = 8'd4;

  localparam logic [COEF_W-1:0] DEN0_RESET = 32'h0001_0000;

  localparam logic signed [65:0] ACC_LIM = 66'sh0_2000_0000_0000_0000;

  typedef struct packed {
    logic valid;
    logic sat;
  } hc_ctl_t;

  typedef struct packed {
    logic valid;
    logic sat;
    logic neg;
    logic nneg;
    logic dz;
    logic ovf;
  } dc_ctl_t;

endpackage

@@ hw/rtl/rational_poly_eval.sv @@
// Rational function evaluator y = N(x) / D(x) with N and D of up to cubic degree.
// Depends on rpe_pkg, rpe_horner_cell and rpe_div_cell.
//
// Coefficients are written through the cfg channel (index 0..3 numerator,
// 4..7 denominator, higher indexes ignored); cfg_ready_o is always high.
// Write them only while no word is in flight.
// Input words x_in_i are taken on in_valid_i & in_ready_o, one per cycle.
// Each word gives one output word (y_out_o, saturated_o, div_by_zero_o),
// taken on out_valid_o & out_ready_i, in the same order.
// A word passes through the Horner cells, the sign and range stage, the
// restoring divider chain with a cell per quotient bit, and the output register.
// Throughput is one word per cycle, but when the receiver stalls, a skid register
// catches one more result and then in_ready_o drops, freezing the chain.
// Reset empties the pipeline and loads the coefficients with N = 0, D = 1.
module rational_poly_eval #(
  parameter int FRAC_BITS = 16,
  parameter int TERMS     = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rpe_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        x_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        y_out_o,
  output logic                      saturated_o,
  output logic                      div_by_zero_o
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int RW = 62 + FRAC_BITS;
  localparam int UW = 62;
  localparam int AW = rpe_pkg::ACC_W;

  logic [31:0] coef_q [rpe_pkg::NREGS];
  logic        en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rpe_pkg::NREGS; i++) begin
        coef_q[i] <= (i == int'(rpe_pkg::REG_DEN0)) ? rpe_pkg::DEN0_RESET : '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < 8'(rpe_pkg::NREGS))) begin
      coef_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  rpe_pkg::hc_ctl_t       nctl [TERMS];
  rpe_pkg::hc_ctl_t       dctl [TERMS];
  logic signed [31:0]     nx   [TERMS];
  logic signed [31:0]     dx   [TERMS];
  logic signed [AW-1:0]   nacc [TERMS];
  logic signed [AW-1:0]   dacc [TERMS];

  assign nctl[0].valid = in_valid_i & in_ready_o;
  assign nctl[0].sat   = 1'b0;
  assign dctl[0]       = nctl[0];
  assign nx[0]         = x_in_i;
  assign dx[0]         = x_in_i;
  assign nacc[0] = AW'($signed(coef_q[rpe_pkg::REG_NUM0[2:0] + 3'(TERMS - 1)]));
  assign dacc[0] = AW'($signed(coef_q[rpe_pkg::REG_DEN0[2:0] + 3'(TERMS - 1)]));

  for (genvar j = 0; j < TERMS - 1; j++) begin : g_horner
    rpe_horner_cell #(.FRAC_BITS(FRAC_BITS)) u_num (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (nctl[j]),
      .x_i    (nx[j]),
      .acc_i  (nacc[j]),
      .coef_i ($signed(coef_q[rpe_pkg::REG_NUM0[2:0] + 3'(TERMS - 2 - j)])),
      .ctl_o  (nctl[j+1]),
      .x_o    (nx[j+1]),
      .acc_o  (nacc[j+1])
    );
    rpe_horner_cell #(.FRAC_BITS(FRAC_BITS)) u_den (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dctl[j]),
      .x_i    (dx[j]),
      .acc_i  (dacc[j]),
      .coef_i ($signed(coef_q[rpe_pkg::REG_DEN0[2:0] + 3'(TERMS - 2 - j)])),
      .ctl_o  (dctl[j+1]),
      .x_o    (dx[j+1]),
      .acc_o  (dacc[j+1])
    );
  end

  logic signed [AW-1:0] n_val, d_val;
  logic [UW-1:0]        un, ud_d;
  rpe_pkg::dc_ctl_t     pctl_d, pctl_q;
  logic [RW-1:0]        prem_q;
  logic [UW-1:0]        pud_q;

  always_comb begin
    n_val        = nacc[TERMS-1];
    d_val        = dacc[TERMS-1];
    un           = n_val[AW-1] ? UW'(-n_val) : UW'(n_val);
    ud_d         = d_val[AW-1] ? UW'(-d_val) : UW'(d_val);
    pctl_d.valid = nctl[TERMS-1].valid;
    pctl_d.sat   = nctl[TERMS-1].sat | dctl[TERMS-1].sat;
    pctl_d.neg   = n_val[AW-1] ^ d_val[AW-1];
    pctl_d.nneg  = n_val[AW-1];
    pctl_d.dz    = (d_val == '0);
    pctl_d.ovf   = (UW'(un[UW-1:32]) >= ud_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
    end else if (en) begin
      pctl_q <= pctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prem_q <= RW'(un) << FRAC_BITS;
      pud_q  <= ud_d;
    end
  end

  rpe_pkg::dc_ctl_t dvctl [QW+1];
  logic [RW-1:0]    dvrem [QW+1];
  logic [UW-1:0]    dvud  [QW+1];
  logic [QW-1:0]    dvquo [QW+1];

  assign dvctl[0] = pctl_q;
  assign dvrem[0] = prem_q;
  assign dvud[0]  = pud_q;
  assign dvquo[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rpe_div_cell #(.RW(RW), .UW(UW), .QW(QW), .BIT_POS(QW - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dvctl[i]),
      .rem_i  (dvrem[i]),
      .ud_i   (dvud[i]),
      .quo_i  (dvquo[i]),
      .ctl_o  (dvctl[i+1]),
      .rem_o  (dvrem[i+1]),
      .ud_o   (dvud[i+1]),
      .quo_o  (dvquo[i+1])
    );
  end

  rpe_pkg::dc_ctl_t   fctl;
  logic [QW-1:0]      fquo, lim;
  logic               big;
  logic [31:0]        qmag;
  logic signed [31:0] res_y;
  logic               res_sat, res_dz;

  always_comb begin
    fctl    = dvctl[QW];
    fquo    = dvquo[QW];
    lim     = fctl.neg ? (QW'(1) << 31) : ((QW'(1) << 31) - QW'(1));
    big     = fctl.ovf | (fquo > lim);
    qmag    = big ? lim[31:0] : fquo[31:0];
    res_y   = fctl.neg ? $signed(-qmag) : $signed(qmag);
    res_sat = fctl.sat | big;
    res_dz  = fctl.dz;
    if (fctl.dz) begin
      res_y   = fctl.nneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res_sat = 1'b1;
    end
  end

  logic               out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic signed [31:0] out_y_q, out_y_d, skid_y_q, skid_y_d;
  logic               out_s_q, out_s_d, skid_s_q, skid_s_d;
  logic               out_z_q, out_z_d, skid_z_q, skid_z_d;
  logic               out_free;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign out_free   = !out_v_q || out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_y_d  = out_y_q;
    out_s_d  = out_s_q;
    out_z_d  = out_z_q;
    skid_v_d = skid_v_q;
    skid_y_d = skid_y_q;
    skid_s_d = skid_s_q;
    skid_z_d = skid_z_q;
    if (skid_v_q) begin
      if (out_free) begin
        out_v_d  = 1'b1;
        out_y_d  = skid_y_q;
        out_s_d  = skid_s_q;
        out_z_d  = skid_z_q;
        skid_v_d = 1'b0;
      end
    end else if (fctl.valid) begin
      if (out_free) begin
        out_v_d = 1'b1;
        out_y_d = res_y;
        out_s_d = res_sat;
        out_z_d = res_dz;
      end else begin
        skid_v_d = 1'b1;
        skid_y_d = res_y;
        skid_s_d = res_sat;
        skid_z_d = res_dz;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_y_q  <= out_y_d;
    out_s_q  <= out_s_d;
    out_z_q  <= out_z_d;
    skid_y_q <= skid_y_d;
    skid_s_q <= skid_s_d;
    skid_z_q <= skid_z_d;
  end

  assign out_valid_o   = out_v_q;
  assign y_out_o       = out_y_q;
  assign saturated_o   = out_s_q;
  assign div_by_zero_o = out_z_q;

endmodule

@@ hw/rtl/rpe_horner_cell.sv @@
// One Horner step: acc * x scaled down by the fraction bits, plus a coefficient,
// with clamping to the accumulator range. Two register stages.
// Depends on rpe_pkg.
module rpe_horner_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rpe_pkg::hc_ctl_t              ctl_i,
  input  logic signed [31:0]            x_i,
  input  logic signed [rpe_pkg::ACC_W-1:0] acc_i,
  input  logic signed [31:0]            coef_i,
  output rpe_pkg::hc_ctl_t              ctl_o,
  output logic signed [31:0]            x_o,
  output logic signed [rpe_pkg::ACC_W-1:0] acc_o
);

  localparam int SH = 32 - FRAC_BITS;
  localparam logic signed [65:0] P_LIM = 66'sd1 <<< (62 - SH);

  rpe_pkg::hc_ctl_t   ctl1_q, ctl2_q, ctl2_d;
  logic signed [31:0] x1_q, x2_q;
  logic signed [63:0] p_q, p_d;
  logic signed [64:0] q_q, q_d;
  logic signed [rpe_pkg::ACC_W-1:0] acc_q, acc_d;

  logic signed [65:0] pw, sum, m, a2;
  logic               sat_m, sat_a;

  assign p_d = 64'($signed(acc_i[63:32])) * 64'(x_i);
  assign q_d = 65'($signed({1'b0, acc_i[31:0]})) * 65'(x_i);

  always_comb begin
    pw    = 66'(p_q);
    sum   = (pw <<< SH) + (66'(q_q) >>> FRAC_BITS);
    sat_m = 1'b1;
    if (pw > P_LIM) begin
      m = rpe_pkg::ACC_LIM;
    end else if (pw < -P_LIM) begin
      m = -rpe_pkg::ACC_LIM;
    end else if (sum > rpe_pkg::ACC_LIM) begin
      m = rpe_pkg::ACC_LIM;
    end else if (sum < -rpe_pkg::ACC_LIM) begin
      m = -rpe_pkg::ACC_LIM;
    end else begin
      m     = sum;
      sat_m = 1'b0;
    end
    a2    = m + 66'(coef_i);
    sat_a = 1'b1;
    if (a2 > rpe_pkg::ACC_LIM) begin
      acc_d = 64'(rpe_pkg::ACC_LIM);
    end else if (a2 < -rpe_pkg::ACC_LIM) begin
      acc_d = 64'(-rpe_pkg::ACC_LIM);
    end else begin
      acc_d = 64'(a2);
      sat_a = 1'b0;
    end
    ctl2_d.valid = ctl1_q.valid;
    ctl2_d.sat   = ctl1_q.sat | sat_m | sat_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= x_i;
      p_q   <= p_d;
      q_q   <= q_d;
      x2_q  <= x1_q;
      acc_q <= acc_d;
    end
  end

  assign ctl_o = ctl2_q;
  assign x_o   = x2_q;
  assign acc_o = acc_q;

endmodule

@@ hw/rtl/rpe_div_cell.sv @@
// One restoring division step: decides quotient bit BIT_POS by comparing the
// partial remainder with the shifted divisor. Depends on rpe_pkg.
module rpe_div_cell #(
  parameter int RW      = 78,
  parameter int UW      = 62,
  parameter int QW      = 48,
  parameter int BIT_POS = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rpe_pkg::dc_ctl_t  ctl_i,
  input  logic [RW-1:0]     rem_i,
  input  logic [UW-1:0]     ud_i,
  input  logic [QW-1:0]     quo_i,
  output rpe_pkg::dc_ctl_t  ctl_o,
  output logic [RW-1:0]     rem_o,
  output logic [UW-1:0]     ud_o,
  output logic [QW-1:0]     quo_o
);

  localparam int CW = ((RW > UW + BIT_POS) ? RW : UW + BIT_POS) + 1;

  rpe_pkg::dc_ctl_t ctl_q;
  logic [RW-1:0]    rem_q, rem_d;
  logic [UW-1:0]    ud_q;
  logic [QW-1:0]    quo_q, quo_d;
  logic [CW-1:0]    r_ext, s_ext, diff;
  logic             ge;

  always_comb begin
    r_ext = CW'(rem_i);
    s_ext = CW'(ud_i) << BIT_POS;
    diff  = r_ext - s_ext;
    ge    = (r_ext >= s_ext);
    rem_d = ge ? RW'(diff) : rem_i;
    quo_d = quo_i;
    quo_d[BIT_POS] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      ud_q  <= ud_i;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign ud_o  = ud_q;
  assign quo_o = quo_q;

endmodule
